// ===== hw/rtl/dnbp_pkg.sv =====
// shared types, constants and helpers of the disk nibble bit stream packer
package dnbp_pkg;

  // command codes of the input word
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_SYNC  = 2'd1;
  localparam logic [1:0] CMD_4AND4 = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  // longest sync run taken from one command
  localparam int MAX_SYNC_RUN = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // bits one command can append: a sync run or two bytes
  localparam int LEN_RAW = $clog2(MAX_SYNC_RUN * 10 + 1);
  localparam int LEN_W   = (LEN_RAW > 5) ? LEN_RAW : 5;

  // running bit total
  localparam int                 TOTAL_W   = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // four-and-four masks
  localparam logic [7:0] ODD_MASK  = 8'b10101010;
  localparam logic [7:0] EVEN_MASK = 8'b01010101;

  // bits of the ten-bit sync word
  localparam int SYNC_WORD_BITS = 10;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_SYNC  = 2'd1,
    OP_FLUSH = 2'd2
  } op_kind_t;

  // one classified command
  typedef struct packed {
    op_kind_t         kind;
    logic [15:0]      bits;   // data bits, first bit in bit 15
    logic [LEN_W-1:0] len;    // number of stream bits to append
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  // eight sync stream bits starting at a phase of the ten-bit word
  function automatic logic [7:0] sync_window(input logic [3:0] phase);
    logic [7:0] w;
    case (phase)
      4'd0:    w = 8'hFF;
      4'd1:    w = 8'hFE;
      4'd2:    w = 8'hFC;
      4'd3:    w = 8'hF9;
      4'd4:    w = 8'hF3;
      4'd5:    w = 8'hE7;
      4'd6:    w = 8'hCF;
      4'd7:    w = 8'h9F;
      4'd8:    w = 8'h3F;
      4'd9:    w = 8'h7F;
      default: w = 8'hFF;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/dnbp_in_if.sv =====
// input channel: one command word per handshake
interface dnbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_value;
  logic [5:0] sync_count;

  modport source (output valid, output cmd, output data_value, output sync_count,
                  input ready);
  modport sink   (input valid, input cmd, input data_value, input sync_count,
                  output ready);
endinterface

// ===== hw/rtl/dnbp_out_if.sv =====
// result channel: one packed track byte per handshake
interface dnbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  packed_byte;
  logic [dnbp_pkg::TOTAL_W-1:0] bits_total;
  logic                        last_of_run;

  modport source (output valid, output packed_byte, output bits_total,
                  output last_of_run, input ready);
  modport sink   (input valid, input packed_byte, input bits_total,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/dnbp_front.sv =====
// front end: accepts command words and classifies them into queue entries
module dnbp_front (
  dnbp_in_if.sink            in_word,
  input  logic               q_full,
  output logic               push,
  output dnbp_pkg::q_entry_t push_entry
);

  logic [5:0]                 cnt_c;
  logic [dnbp_pkg::LEN_W-1:0] cnt_ext;
  logic [7:0]                 enc_odd;
  logic [7:0]                 enc_even;
  logic                       accept;

  // take a word whenever the queue has room
  assign in_word.ready = !q_full;
  assign accept        = in_word.valid && !q_full;

  // clamp sync run and widen it; the classifier scales it by the word length (x8 + x2)
  assign cnt_c   = (in_word.sync_count > 6'(dnbp_pkg::MAX_SYNC_RUN)) ?
                   6'(dnbp_pkg::MAX_SYNC_RUN) : in_word.sync_count;
  assign cnt_ext = dnbp_pkg::LEN_W'(cnt_c);

  // four-and-four halves
  assign enc_odd  = ((in_word.data_value & dnbp_pkg::ODD_MASK) >> 1) | dnbp_pkg::ODD_MASK;
  assign enc_even = (in_word.data_value & dnbp_pkg::EVEN_MASK) | dnbp_pkg::ODD_MASK;

  // classify
  always_comb begin
    push_entry.kind = dnbp_pkg::OP_DATA;
    push_entry.bits = {in_word.data_value, 8'h00};
    push_entry.len  = dnbp_pkg::LEN_W'(8);
    push            = accept;
    case (in_word.cmd)
      dnbp_pkg::CMD_DATA: begin
        push_entry.kind = dnbp_pkg::OP_DATA;
      end
      dnbp_pkg::CMD_SYNC: begin
        push_entry.kind = dnbp_pkg::OP_SYNC;
        push_entry.len  = (cnt_ext << 3) + (cnt_ext << 1);
        // an empty sync run appends nothing
        push            = accept && (cnt_c != 6'd0);
      end
      dnbp_pkg::CMD_4AND4: begin
        push_entry.kind = dnbp_pkg::OP_DATA;
        push_entry.bits = {enc_odd, enc_even};
        push_entry.len  = dnbp_pkg::LEN_W'(16);
      end
      dnbp_pkg::CMD_FLUSH: begin
        push_entry.kind = dnbp_pkg::OP_FLUSH;
      end
      default: begin
        push_entry.kind = dnbp_pkg::OP_DATA;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dnbp_queue.sv =====
// short command queue between front end and bit packer
module dnbp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dnbp_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output dnbp_pkg::q_entry_t head
);

  dnbp_pkg::q_entry_t                entry_r [dnbp_pkg::QUEUE_DEPTH];
  logic [dnbp_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dnbp_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dnbp_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign full       = (count_r == dnbp_pkg::QCNT_W'(dnbp_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dnbp_pkg::QPTR_W'(dnbp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dnbp_pkg::QPTR_W'(dnbp_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/dnbp_back.sv =====
// back end: appends queued bits to the stream and emits one byte per cycle while the output is not stalled
module dnbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  dnbp_pkg::q_entry_t head,
  output logic               pop,
  dnbp_out_if.source         out_word
);

  localparam int LW = dnbp_pkg::LEN_W;
  localparam int TW = dnbp_pkg::TOTAL_W;

  dnbp_pkg::back_state_t state_r, state_nxt;

  // stream state
  logic [6:0]    partial_r, partial_nxt;
  logic [2:0]    fill_r, fill_nxt;
  logic [TW-1:0] total_r, total_nxt;

  // current source of bits
  logic              sync_r, sync_nxt;
  logic [15:0]       sreg_r, sreg_nxt;
  logic [3:0]        phase_r, phase_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [TW-1:0] obits_r, obits_nxt;
  logic          olast_r, olast_nxt;

  logic          adv;
  logic [7:0]    win;
  logic [14:0]   comb_run;
  logic [14:0]   comb_flush;
  logic [3:0]    k;
  logic [LW-1:0] rem_after;
  logic          last;
  logic [2:0]    tail;
  logic [4:0]    phase_sum;
  logic [3:0]    phase_adv;
  logic [15:0]   sreg_adv;
  logic [7:0]    win_adv;
  logic [7:0]    tail_bits;
  logic [TW:0]   sum_byte;
  logic [TW:0]   sum_end;
  logic [TW-1:0] total_byte;
  logic [TW-1:0] total_end;

  assign out_word.valid       = out_valid_r;
  assign out_word.packed_byte = byte_r;
  assign out_word.bits_total  = obits_r;
  assign out_word.last_of_run = olast_r;

  // output register can be loaded
  assign adv = !out_valid_r || out_word.ready;

  // next byte: pending bits followed by the source window
  assign win        = sync_r ? dnbp_pkg::sync_window(phase_r) : sreg_r[15:8];
  assign comb_run   = {partial_r, win} >> fill_r;
  assign comb_flush = {partial_r, 8'h00} >> fill_r;
  assign k          = 4'd8 - {1'b0, fill_r};

  // bits left in the source after this byte
  assign rem_after = rem_r - LW'(k);
  assign last      = (rem_after < LW'(8));
  assign tail      = rem_after[2:0];

  // advance the source by k bits
  assign phase_sum = {1'b0, phase_r} + {1'b0, k};
  assign phase_adv = (phase_sum >= 5'(dnbp_pkg::SYNC_WORD_BITS)) ?
                     4'(phase_sum - 5'(dnbp_pkg::SYNC_WORD_BITS)) : phase_sum[3:0];
  assign sreg_adv  = sreg_r << k;
  assign win_adv   = sync_r ? dnbp_pkg::sync_window(phase_adv) : sreg_adv[15:8];
  assign tail_bits = win_adv >> (4'd8 - {1'b0, tail});

  // saturating bit totals
  assign sum_byte   = {1'b0, total_r} + (TW+1)'(k);
  assign sum_end    = sum_byte + (TW+1)'(tail);
  assign total_byte = sum_byte[TW] ? dnbp_pkg::TOTAL_MAX : sum_byte[TW-1:0];
  assign total_end  = sum_end[TW]  ? dnbp_pkg::TOTAL_MAX : sum_end[TW-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    partial_nxt   = partial_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    sync_nxt      = sync_r;
    sreg_nxt      = sreg_r;
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    byte_nxt      = byte_r;
    obits_nxt     = obits_r;
    olast_nxt     = olast_r;
    pop           = 1'b0;
    case (state_r)
      dnbp_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.kind == dnbp_pkg::OP_FLUSH) begin
            // pending bits padded with zeros, state untouched
            if (adv) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              byte_nxt      = comb_flush[7:0];
              obits_nxt     = total_r;
              olast_nxt     = 1'b1;
            end
          end else begin
            // load the source
            pop       = 1'b1;
            sync_nxt  = (head.kind == dnbp_pkg::OP_SYNC);
            sreg_nxt  = head.bits;
            phase_nxt = '0;
            rem_nxt   = head.len;
            state_nxt = dnbp_pkg::ST_RUN;
          end
        end
      end
      dnbp_pkg::ST_RUN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          byte_nxt      = comb_run[7:0];
          obits_nxt     = total_byte;
          olast_nxt     = last;
          sreg_nxt      = sreg_adv;
          phase_nxt     = phase_adv;
          rem_nxt       = rem_after;
          if (last) begin
            // leftover bits become the pending partial byte
            partial_nxt = tail_bits[6:0];
            fill_nxt    = tail;
            total_nxt   = total_end;
            state_nxt   = dnbp_pkg::ST_IDLE;
          end else begin
            partial_nxt = '0;
            fill_nxt    = '0;
            total_nxt   = total_byte;
          end
        end
      end
      default: begin
        state_nxt = dnbp_pkg::ST_IDLE;
      end
    endcase
  end

  // control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnbp_pkg::ST_IDLE;
      partial_r   <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // source and output payload
  always_ff @(posedge clk) begin
    sync_r  <= sync_nxt;
    sreg_r  <= sreg_nxt;
    phase_r <= phase_nxt;
    rem_r   <= rem_nxt;
    byte_r  <= byte_nxt;
    obits_r <= obits_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ===== hw/rtl/disk_nibble_bitstream_packer_unit.sv =====
// top level of the disk nibble bit stream packer
// Packs a disk-track bit stream, first bit in bit 7, into bytes. Command words
// (raw byte, sync run of ten-bit 0x3FC words, four-and-four byte, flush) enter
// a four-entry queue and are taken in while earlier commands are still being
// packed. The packer loads a command, then gives out one byte per cycle unless
// the output stalls: a raw byte gives one byte, a four-and-four byte two, a
// sync run of n words floor((pending + 10n) / 8) with n capped at 32, and a
// flush one. The single-byte-per-cycle packer sets the rate; each byte carries
// the saturating count of stream bits written so far, and the last byte of
// each command is flagged. A flush returns the pending bits padded with zeros
// and leaves the stream as it was; an empty sync run gives nothing.
module disk_nibble_bitstream_packer_unit (
  input  logic       clk,
  input  logic       rst_n,
  dnbp_in_if.sink    in_word,
  dnbp_out_if.source out_word
);

  logic               q_full;
  logic               push;
  dnbp_pkg::q_entry_t push_entry;
  logic               pop;
  logic               head_valid;
  dnbp_pkg::q_entry_t head;

  // accept and classify
  dnbp_front u_front (
    .in_word    (in_word),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // command queue
  dnbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // bit packer
  dnbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_word   (out_word)
  );

`ifndef NO_ASSERTIONS
  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command pushed into full queue");

  // never read an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command popped from empty queue");

  // a flush taken by the packer shows up as a final byte next cycle
  a_flush_out: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == dnbp_pkg::OP_FLUSH) |=> (out_word.valid && out_word.last_of_run))
    else $error("flush did not produce a final byte");
`endif

endmodule
